>>> design/ole_pkg.sv
// ole_pkg: shared types and constants for the ordered list engine
// no dependencies; imported by ole_ctrl, ole_datapath and ordered_list_engine
package ole_pkg;

    localparam int unsigned DEF_CAPACITY = 64;

    localparam int unsigned REQ_W   = 3;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 8;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned LEN_W   = 7;

    localparam int unsigned S_DATA_W = 40;
    localparam int unsigned S_USER_W = 3;
    localparam int unsigned M_DATA_W = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_HEAD = 3'd0,
        REQ_INS_TAIL = 3'd1,
        REQ_INS_POS  = 3'd2,
        REQ_DEL_HEAD = 3'd3,
        REQ_DEL_TAIL = 3'd4,
        REQ_DEL_POS  = 3'd5,
        REQ_SEARCH   = 3'd6
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_INVALID = 3'd2,
        ST_OOB     = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

endpackage

>>> design/ole_ctrl.sv
// ole_ctrl: request sequencer and output word handshake
// depends on ole_pkg; drives the command struct into ole_datapath
module ole_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output ole_pkg::cmd_t cmd
);
    import ole_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free    = !out_valid_reg || m_tready;
    assign s_tready    = (state_reg == ST_IDLE);
    assign cmd.capture = s_tvalid && s_tready;
    assign cmd.commit  = (state_reg == ST_EXEC) && out_free;
    assign m_tvalid    = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.capture) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd.commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_commit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> out_valid_reg)
        else $error("result word not presented after commit");

    a_capture_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == ST_EXEC))
        else $error("accepted word did not start execution");

    a_hold_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_EXEC) && out_valid_reg && !m_tready) |=> (state_reg == ST_EXEC))
        else $error("request left execution while output blocked");

    a_cmd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.capture && cmd.commit))
        else $error("capture and commit in the same cycle");
`endif

endmodule

>>> design/ole_datapath.sv
// ole_datapath: shift-register list cells, entry count and result registers
// depends on ole_pkg; steered by the command struct from ole_ctrl
module ole_datapath #(
    parameter int unsigned CAPACITY = ole_pkg::DEF_CAPACITY
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ole_pkg::cmd_t               cmd,
    input  logic [ole_pkg::REQ_W-1:0]   s_req_type,
    input  logic [ole_pkg::VALUE_W-1:0] s_value,
    input  logic [ole_pkg::POS_W-1:0]   s_position,
    output logic [ole_pkg::STAT_W-1:0]  m_status,
    output logic                        m_found,
    output logic [ole_pkg::LEN_W-1:0]   m_length
);
    import ole_pkg::*;

    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned CMPW = (CW + 1 > POS_W + 1) ? CW + 1 : POS_W + 1;

    logic [VALUE_W-1:0] cell_reg  [CAPACITY];
    logic [VALUE_W-1:0] cell_next [CAPACITY];
    logic [CAPACITY-1:0] match_reg, match_next;

    logic [CW-1:0]      count_reg, count_next;
    req_t               req_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [POS_W-1:0]   pos_reg;

    logic [STAT_W-1:0]  status_reg;
    logic               found_reg;
    logic [LEN_W-1:0]   length_reg;

    logic [CMPW-1:0]    cnt_ext, pos_ext, idx, cnt_next_ext;
    status_t            status_w;
    logic               do_ins, do_del, found_w;

    assign cnt_ext = CMPW'(count_reg);
    assign pos_ext = CMPW'(pos_reg);

    always_comb begin
        status_w = ST_OK;
        do_ins   = 1'b0;
        do_del   = 1'b0;
        found_w  = 1'b0;
        idx      = '0;
        case (req_reg)
            REQ_INS_HEAD, REQ_INS_TAIL: begin
                if (cnt_ext >= CMPW'(CAPACITY)) begin
                    status_w = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                    idx    = (req_reg == REQ_INS_HEAD) ? '0 : cnt_ext;
                end
            end
            REQ_INS_POS: begin
                if (pos_reg == '0) begin
                    status_w = ST_INVALID;
                end else if (pos_ext > cnt_ext + CMPW'(1)) begin
                    status_w = ST_OOB;
                end else if (cnt_ext >= CMPW'(CAPACITY)) begin
                    status_w = ST_FULL;
                end else begin
                    do_ins = 1'b1;
                    idx    = pos_ext - CMPW'(1);
                end
            end
            REQ_DEL_HEAD, REQ_DEL_TAIL: begin
                if (count_reg == '0) begin
                    status_w = ST_EMPTY;
                end else begin
                    do_del = 1'b1;
                    idx    = (req_reg == REQ_DEL_HEAD) ? '0 : cnt_ext - CMPW'(1);
                end
            end
            REQ_DEL_POS: begin
                if (count_reg == '0) begin
                    status_w = ST_EMPTY;
                end else if (pos_reg == '0) begin
                    status_w = ST_INVALID;
                end else if (pos_ext > cnt_ext) begin
                    status_w = ST_OOB;
                end else begin
                    do_del = 1'b1;
                    idx    = pos_ext - CMPW'(1);
                end
            end
            REQ_SEARCH: begin
                found_w = |match_reg;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (do_ins) begin
            cnt_next_ext = cnt_ext + CMPW'(1);
        end else if (do_del) begin
            cnt_next_ext = cnt_ext - CMPW'(1);
        end else begin
            cnt_next_ext = cnt_ext;
        end
    end
    assign count_next = cnt_next_ext[CW-1:0];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_W-1:0] up_w, dn_w;
        if (g == 0) begin : g_first
            assign up_w = value_reg;
        end else begin : g_mid
            assign up_w = cell_reg[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign dn_w = cell_reg[g];
        end else begin : g_body
            assign dn_w = cell_reg[g+1];
        end

        always_comb begin
            cell_next[g] = cell_reg[g];
            if (do_ins) begin
                if (CMPW'(g) == idx) begin
                    cell_next[g] = value_reg;
                end else if (CMPW'(g) > idx) begin
                    cell_next[g] = up_w;
                end
            end else if (do_del && (CMPW'(g) >= idx)) begin
                cell_next[g] = dn_w;
            end
        end

        // per-cell compare against the incoming key, registered before the reduction
        assign match_next[g] = (CMPW'(g) < cnt_ext) && (cell_reg[g] == s_value);

        always_ff @(posedge aclk) begin
            if (cmd.commit) begin
                cell_reg[g] <= cell_next[g];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg   <= req_t'(s_req_type);
            value_reg <= s_value;
            pos_reg   <= s_position;
            match_reg <= match_next;
        end
        if (cmd.commit) begin
            status_reg <= status_w;
            found_reg  <= found_w;
            length_reg <= cnt_next_ext[LEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.commit) begin
            count_reg <= count_next;
        end
    end

    assign m_status = status_reg;
    assign m_found  = found_reg;
    assign m_length = length_reg;

endmodule

>>> design/ordered_list_engine.sv
// ordered_list_engine: top level of the ordered list engine
// depends on ole_pkg, ole_ctrl and ole_datapath
//
//  channel  | dir | tdata (low bit up)                       | tuser
//  s_ words | in  | value[31:0], position[39:32]             | req_type[2:0]
//  m_ words | out | status[2:0], found[3], length[10:4]      | -
//
// each request is first captured with a per-cell key compare, then commits the shifted
// cells, count and result word into the output register
// a new word is taken while the previous result still waits on m_tready
// a blocked output holds the request in commit until the result register frees
// aresetn clears the entry count and handshake state; cell contents are not reset
module ordered_list_engine #(
    parameter int unsigned CAPACITY = ole_pkg::DEF_CAPACITY
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ole_pkg::S_DATA_W-1:0]  s_tdata,   // value, position
    input  logic [ole_pkg::S_USER_W-1:0]  s_tuser,   // req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ole_pkg::M_DATA_W-1:0]  m_tdata    // status, found, length
);
    import ole_pkg::*;

    cmd_t              cmd;
    logic [STAT_W-1:0] status_w;
    logic              found_w;
    logic [LEN_W-1:0]  length_w;

    ole_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ole_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .s_req_type (s_tuser[REQ_W-1:0]),
        .s_value    (s_tdata[VALUE_W-1:0]),
        .s_position (s_tdata[VALUE_W+POS_W-1:VALUE_W]),
        .m_status   (status_w),
        .m_found    (found_w),
        .m_length   (length_w)
    );

    assign m_tdata = {{(M_DATA_W - STAT_W - 1 - LEN_W){1'b0}}, length_w, found_w, status_w};

endmodule

>>> dv/tb_top.sv
// tb_top: self-checking bench for ordered_list_engine, with a list predictor,
// random idling on both stream sides and one long receiver hold-off
// depends on ole_pkg and the ordered_list_engine rtl
`timescale 1ns / 100ps

module tb_top;
    import ole_pkg::*;

    localparam int unsigned CAPACITY    = DEF_CAPACITY;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        status_t          status;
        logic             found;
        logic [LEN_W-1:0] length;
    } list_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;     // value, position
    logic [S_USER_W-1:0] s_tuser  = '0;     // req_type
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;           // status, found, length

    logic [VALUE_W-1:0] list_q[$];
    list_result_t       pending_results[$];
    list_result_t       want;
    int                 mismatch_cnt = 0;
    int                 cycle_cnt    = 0;
    int                 hold_len     = 0;
    bit                 tx_idle      = 1'b1;
    bit                 rx_idle      = 1'b1;

    ordered_list_engine #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("ordered_list_engine verification failed");
            $finish;
        end
    end

    function automatic list_result_t apply_request(input logic [REQ_W-1:0] req,
                                                   input logic [VALUE_W-1:0] val,
                                                   input logic [POS_W-1:0] pos);
        list_result_t r;
        int len;
        len = list_q.size();
        r.status = ST_OK;
        r.found  = 1'b0;
        case (req)
            REQ_INS_HEAD, REQ_INS_TAIL: begin
                if (len >= CAPACITY)
                    r.status = ST_FULL;
                else if (req == REQ_INS_HEAD)
                    list_q.push_front(val);
                else
                    list_q.push_back(val);
            end
            REQ_INS_POS: begin
                if (pos == 0)
                    r.status = ST_INVALID;
                else if (int'(pos) > len + 1)
                    r.status = ST_OOB;
                else if (len >= CAPACITY)
                    r.status = ST_FULL;
                else
                    list_q.insert(int'(pos) - 1, val);
            end
            REQ_DEL_HEAD, REQ_DEL_TAIL: begin
                if (len == 0)
                    r.status = ST_EMPTY;
                else if (req == REQ_DEL_HEAD)
                    void'(list_q.pop_front());
                else
                    void'(list_q.pop_back());
            end
            REQ_DEL_POS: begin
                if (len == 0)
                    r.status = ST_EMPTY;
                else if (pos == 0)
                    r.status = ST_INVALID;
                else if (int'(pos) > len)
                    r.status = ST_OOB;
                else
                    list_q.delete(int'(pos) - 1);
            end
            REQ_SEARCH: begin
                foreach (list_q[i])
                    if (list_q[i] == val)
                        r.found = 1'b1;
            end
            default: ;
        endcase
        r.length = LEN_W'(list_q.size());
        return r;
    endfunction

    task automatic push_request(input logic [REQ_W-1:0] req, input logic [VALUE_W-1:0] val,
                                input logic [POS_W-1:0] pos);
        int gap;
        gap = tx_idle ? $urandom_range(10) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {pos, val};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_request(req, val, pos));
    endtask

    // receiver: random gap before each word, plus an optional long hold-off
    initial begin
        int gap;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_len > 0) begin
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
            end
            gap = rx_idle ? $urandom_range(10) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result word %h", m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[2:0] != want.status || m_tdata[3] != want.found
                        || m_tdata[10:4] != want.length) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: status %0d/%0d found %0d/%0d length %0d/%0d",
                                 want.status, m_tdata[2:0], want.found, m_tdata[3],
                                 want.length, m_tdata[10:4]);
                end
            end
        end
    end

    task automatic test_directed();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        push_request(REQ_DEL_HEAD, 32'h0, 8'd0);
        push_request(REQ_DEL_TAIL, 32'h0, 8'd0);
        push_request(REQ_DEL_POS, 32'h0, 8'd1);
        push_request(REQ_DEL_POS, 32'h0, 8'd0);
        push_request(REQ_INS_POS, 32'h1111_1111, 8'd0);
        push_request(REQ_INS_POS, 32'h2222_2222, 8'd2);
        push_request(REQ_SEARCH, 32'h0, 8'd0);
        push_request(REQ_INS_POS, 32'h8000_0000, 8'd1);
        push_request(REQ_INS_HEAD, 32'h7fff_ffff, 8'd0);
        push_request(REQ_INS_TAIL, 32'h0, 8'd0);
        push_request(REQ_INS_TAIL, 32'hffff_ffff, 8'd0);
        push_request(REQ_INS_POS, 32'h5555_5555, 8'd5);
        push_request(REQ_INS_POS, 32'haaaa_aaaa, 8'd255);
        push_request(REQ_INS_POS, 32'h1, 8'd3);
        push_request(REQ_SEARCH, 32'h8000_0000, 8'd0);
        push_request(REQ_SEARCH, 32'h1234_5678, 8'd0);
        push_request(REQ_UNUSED, 32'hffff_ffff, 8'd255);
        push_request(REQ_DEL_POS, 32'h0, 8'd0);
        push_request(REQ_DEL_POS, 32'h0, 8'd7);
        push_request(REQ_DEL_POS, 32'h0, 8'd255);
        push_request(REQ_DEL_POS, 32'h0, 8'd3);
        push_request(REQ_DEL_HEAD, 32'h0, 8'd0);
        push_request(REQ_DEL_TAIL, 32'h0, 8'd0);
        push_request(REQ_DEL_POS, 32'h0, 8'd3);
        push_request(REQ_SEARCH, 32'h7fff_ffff, 8'd0);
    endtask

    task automatic test_fill_drain();
        int len;
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        while (list_q.size() < CAPACITY) begin
            len = list_q.size();
            push_request(REQ_W'($urandom_range(2)), $urandom,
                         POS_W'($urandom_range(len + 1, 1)));
        end
        push_request(REQ_INS_HEAD, $urandom, 8'd0);
        push_request(REQ_INS_TAIL, $urandom, 8'd0);
        push_request(REQ_INS_POS, $urandom, POS_W'(CAPACITY + 1));
        push_request(REQ_INS_POS, $urandom, POS_W'(CAPACITY + 2));
        push_request(REQ_INS_POS, $urandom, 8'd0);
        push_request(REQ_SEARCH, list_q[CAPACITY-1], 8'd0);
        push_request(REQ_DEL_POS, 32'h0, POS_W'(CAPACITY));
        rx_idle = 1'b0;
        while (list_q.size() > 0) begin
            len = list_q.size();
            push_request(REQ_W'($urandom_range(5, 3)), $urandom,
                         POS_W'($urandom_range(len, 1)));
        end
        push_request(REQ_DEL_POS, 32'h0, 8'd255);
        push_request(REQ_DEL_TAIL, 32'h0, 8'd0);
    endtask

    // receiver stalls for a long stretch while words keep coming
    task automatic test_backpressure();
        tx_idle  = 1'b0;
        rx_idle  = 1'b0;
        hold_len = 400;
        repeat (40)
            push_request(REQ_W'($urandom_range(2)), $urandom, POS_W'($urandom_range(3)));
    endtask

    task automatic test_random(input int n_words);
        bit               ins_bias;
        int               len;
        int               roll;
        logic [REQ_W-1:0] req;
        logic [VALUE_W-1:0] val;
        logic [POS_W-1:0] pos;
        ins_bias = 1'b1;
        for (int k = 0; k < n_words; k++) begin
            if (k % 100 == 0) begin
                ins_bias = ~ins_bias;
                tx_idle  = $urandom_range(3) != 0;
                rx_idle  = $urandom_range(3) != 0;
            end
            len  = list_q.size();
            roll = $urandom_range(99);
            if (roll < 5)
                req = REQ_UNUSED;
            else if (roll < 20)
                req = REQ_SEARCH;
            else if (roll < (ins_bias ? 85 : 50))
                req = REQ_W'($urandom_range(2));
            else
                req = REQ_W'($urandom_range(5, 3));
            case ($urandom_range(3))
                0: val = $urandom;
                1: val = $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
                default: val = VALUE_W'($urandom_range(15)) - 32'd8;
            endcase
            if (req == REQ_SEARCH && len > 0 && $urandom_range(1))
                val = list_q[$urandom_range(len - 1)];
            if ($urandom_range(9) == 0)
                pos = POS_W'($urandom_range(255));
            else
                pos = POS_W'($urandom_range(len + 2));
            push_request(req, val, pos);
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_fill_drain();
        test_backpressure();
        test_random(1150);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("ordered_list_engine verification clean");
        else
            $display("ordered_list_engine verification failed");
        $finish;
    end

endmodule

>>> ordered_list_engine.f
design/ole_pkg.sv
design/ole_ctrl.sv
design/ole_datapath.sv
design/ordered_list_engine.sv
dv/tb_top.sv
